FILE: sv/bdus_pkg.sv
package bdus_pkg;

  localparam int unsigned BcdW   = 8;
  localparam int unsigned ValW   = 7;   // decoded two-digit value, 0..99
  localparam int unsigned DaysW  = 16;  // days since epoch, below 37000
  localparam int unsigned TodW   = 19;  // h*3600 + m*60 + s for fields up to 99
  localparam int unsigned SecW   = 32;
  localparam int unsigned InW    = 6 * BcdW;

  localparam logic [ValW-1:0]  YearPivot   = 7'd70;
  localparam logic [ValW-1:0]  CenturyAdj  = 7'd30;  // 2000 - 1970
  localparam logic [8:0]       DaysPerYear = 9'd365;
  localparam logic [11:0]      SecPerHour  = 12'd3600;
  localparam logic [5:0]       SecPerMin   = 6'd60;
  localparam logic [16:0]      SecPerDay   = 17'd86400;
  localparam logic [ValW-1:0]  MonthFeb    = 7'd2;
  localparam logic [ValW-1:0]  MonthDec    = 7'd12;

  // Decoded fields after the first stage
  typedef struct packed {
    logic [ValW-1:0] sec;
    logic [ValW-1:0] min;
    logic [ValW-1:0] hour;
    logic [ValW-1:0] day;
    logic [ValW-1:0] mon;
    logic [ValW-1:0] yoff;  // years since 1970
    logic            leap;
    logic            bad;
  } dec_t;

  // Day count and time of day after the second stage
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
    logic             bad;
  } cal_t;

  // Days before the first of a month, non-leap year; month given 1..12
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/bcd_datetime_to_unix_seconds_unit.sv
// BCD calendar to epoch seconds converter.
//
// Input stream: in_tdata carries one calendar transaction of six BCD bytes
// (seconds, minutes, hours, day, month, two-digit year). Output stream:
// out_tdata holds the seconds since 1970-01-01 00:00:00 and out_tuser flags
// a rejected input (bad BCD digit, month outside 1..12, or day zero), in
// which case out_tdata is zero. Years below 70 are 20xx, others 19xx.
//
// Four register stages: BCD decode, day count and time of day, day scaling
// by 86400, final add. While the receiver keeps out_tready high, one
// transaction is accepted per cycle, since every stage registers its work
// and can take a new transaction in each cycle.
//
// Reset clears all stage valid bits; the pipeline comes out empty. When the
// receiver holds out_tready low, the last stage holds and earlier stages
// keep filling any empty slots; in_tready drops only when all four are full.
module bcd_datetime_to_unix_seconds_unit
  import bdus_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [InW-1:0] in_tdata,   // sec, min, hour, day, month, year (8b each)
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [SecW-1:0] out_tdata, // epoch_seconds
  output logic           out_tuser   // bad_input
);

  dec_t dec_nxt, s1_r;
  cal_t cal_nxt, s2_r;

  logic [SecW-1:0] prod_nxt, prod_r;
  logic [TodW-1:0] tod3_r;
  logic            bad3_r;
  logic [SecW-1:0] secs_nxt, secs_r;
  logic            bad4_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // Each stage advances when its slot is empty or its successor advances
  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  bdus_decode u_decode (
    .raw (in_tdata),
    .dec (dec_nxt)
  );

  bdus_calendar u_calendar (
    .dec (s1_r),
    .cal (cal_nxt)
  );

  // Scale whole days to seconds
  assign prod_nxt = SecW'(s2_r.days) * SecW'(SecPerDay);
  // Add time of day; flagged inputs give zero
  assign secs_nxt = bad3_r ? '0 : (prod_r + SecW'(tod3_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= dec_nxt;
    if (en2) s2_r <= cal_nxt;
    if (en3) begin
      prod_r <= prod_nxt;
      tod3_r <= s2_r.tod;
      bad3_r <= s2_r.bad;
    end
    if (en4) begin
      secs_r <= secs_nxt;
      bad4_r <= bad3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = secs_r;
  assign out_tuser  = bad4_r;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("flagged result carries nonzero seconds");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && v3_r && v4_r && !out_tready)
    else $error("input stalled with an empty slot in the pipeline");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_tready |=> v4_r && $stable(secs_r) && $stable(bad4_r))
    else $error("last stage changed while receiver stalled");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !v4_r |=> v4_r)
    else $error("stage three failed to advance into an empty last stage");
`endif

endmodule

FILE: sv/bdus_decode.sv
module bdus_decode
  import bdus_pkg::*;
(
  input  logic [InW-1:0] raw,
  output dec_t           dec
);

  logic [5:0]      digit_bad;
  logic [ValW-1:0] val [6];
  logic            range_bad;

  // Decode each byte once: hi*10 + lo
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      logic [3:0] hi;
      logic [3:0] lo;
      hi = raw[i*BcdW+4 +: 4];
      lo = raw[i*BcdW +: 4];
      digit_bad[i] = (hi > 4'd9) || (lo > 4'd9);
      val[i] = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    end
  end

  assign range_bad = (val[4] == '0) || (val[4] > MonthDec) || (val[3] == '0);

  always_comb begin
    dec.sec  = val[0];
    dec.min  = val[1];
    dec.hour = val[2];
    dec.day  = val[3];
    dec.mon  = val[4];
    // Below the pivot the year is 20xx, otherwise 19xx
    dec.yoff = (val[5] < YearPivot) ? (val[5] + CenturyAdj) : (val[5] - YearPivot);
    // Only century in range is 2000, a leap year, so the plain rule of four holds
    dec.leap = (val[5][1:0] == 2'b00);
    dec.bad  = (|digit_bad) || range_bad;
  end

endmodule

FILE: sv/bdus_calendar.sv
module bdus_calendar
  import bdus_pkg::*;
(
  input  dec_t dec,
  output cal_t cal
);

  logic [DaysW-1:0] year_days;
  logic [5:0]       leap_days;
  logic [DaysW-1:0] extra;

  // Leap days before the year; the century terms cancel over 1970..2069
  assign year_days = DaysW'(dec.yoff) * DaysW'(DaysPerYear);
  assign leap_days = 6'((dec.yoff + 7'd1) >> 2);
  assign extra     = DaysW'(month_start(dec.mon[3:0]))
                   + DaysW'(dec.leap && (dec.mon > MonthFeb))
                   + DaysW'(dec.day - 7'd1);

  always_comb begin
    cal.days = year_days + DaysW'(leap_days) + extra;
    cal.tod  = TodW'(dec.hour) * TodW'(SecPerHour) + TodW'(dec.min) * TodW'(SecPerMin)
             + TodW'(dec.sec);
    cal.bad  = dec.bad;
  end

endmodule
